// ===== sv/hpcs_pkg.sv =====
package hpcs_pkg;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXT_SLOW    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXT_FAST    = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INT_FAST    = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFROST_THR = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_VALVE_DLY   = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMP_DLY    = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFROST_TM  = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIP_TM     = 4'd7;

   // Configuration reset values.
   localparam logic signed [11:0] EXT_SLOW_RESET    = 12'sd160;
   localparam logic signed [11:0] EXT_FAST_RESET    = 12'sd200;
   localparam logic signed [11:0] INT_FAST_RESET    = 12'sd240;
   localparam logic signed [11:0] DEFROST_THR_RESET = -12'sd50;
   localparam logic [15:0]        VALVE_DLY_RESET   = 16'd60;
   localparam logic [15:0]        COMP_DLY_RESET    = 16'd180;
   localparam logic [15:0]        DEFROST_TM_RESET  = 16'd300;
   localparam logic [15:0]        DRIP_TM_RESET     = 16'd120;

   // One input item.
   typedef struct packed {
      logic signed [11:0] outdoor_unit_temp;
      logic signed [11:0] indoor_unit_temp;
      logic signed [11:0] evaporator_temp;
      logic [31:0]        now_seconds;
   } req_type;

   // One result item.
   typedef struct packed {
      logic compressor_pin;
      logic outdoor_fan_pin;
      logic outdoor_fast_pin;
      logic indoor_fan_pin;
      logic indoor_fast_pin;
      logic valve_pin;
      logic defrost_active;
      logic drip_active;
   } rsp_type;

   // Configuration registers as seen by the sequencing logic.
   typedef struct packed {
      logic signed [11:0] ext_slow_threshold;
      logic signed [11:0] ext_fast_threshold;
      logic signed [11:0] int_fast_threshold;
      logic signed [11:0] defrost_threshold;
      logic [15:0]        valve_delay;
      logic [15:0]        compressor_delay;
      logic [15:0]        defrost_time;
      logic [15:0]        drip_time;
   } cfg_type;

   // True when at least delay seconds have passed since start, modulo 2^32.
   function automatic logic elapsed(input logic [31:0] now,
                                    input logic [31:0] start,
                                    input logic [15:0] delay);
      logic [31:0] diff;
      diff = now - start;
      return diff >= {16'd0, delay};
   endfunction

endpackage

// ===== sv/hpcs_csr.sv =====
module hpcs_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [hpcs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                      csr_wdata,
   output hpcs_pkg::cfg_type                cfg
);

   hpcs_pkg::cfg_type cfg_ff;
   hpcs_pkg::cfg_type cfg_in;

   // Writes are always taken; an index beyond the register list is dropped.
   assign csr_ready = 1'b1;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            hpcs_pkg::CSR_EXT_SLOW:    cfg_in.ext_slow_threshold = csr_wdata[11:0];
            hpcs_pkg::CSR_EXT_FAST:    cfg_in.ext_fast_threshold = csr_wdata[11:0];
            hpcs_pkg::CSR_INT_FAST:    cfg_in.int_fast_threshold = csr_wdata[11:0];
            hpcs_pkg::CSR_DEFROST_THR: cfg_in.defrost_threshold  = csr_wdata[11:0];
            hpcs_pkg::CSR_VALVE_DLY:   cfg_in.valve_delay        = csr_wdata;
            hpcs_pkg::CSR_COMP_DLY:    cfg_in.compressor_delay   = csr_wdata;
            hpcs_pkg::CSR_DEFROST_TM:  cfg_in.defrost_time       = csr_wdata;
            hpcs_pkg::CSR_DRIP_TM:     cfg_in.drip_time          = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ext_slow_threshold <= hpcs_pkg::EXT_SLOW_RESET;
         cfg_ff.ext_fast_threshold <= hpcs_pkg::EXT_FAST_RESET;
         cfg_ff.int_fast_threshold <= hpcs_pkg::INT_FAST_RESET;
         cfg_ff.defrost_threshold  <= hpcs_pkg::DEFROST_THR_RESET;
         cfg_ff.valve_delay        <= hpcs_pkg::VALVE_DLY_RESET;
         cfg_ff.compressor_delay   <= hpcs_pkg::COMP_DLY_RESET;
         cfg_ff.defrost_time       <= hpcs_pkg::DEFROST_TM_RESET;
         cfg_ff.drip_time          <= hpcs_pkg::DRIP_TM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/hpcs_core.sv =====
module hpcs_core (
   input  logic              clock,
   input  logic              reset,
   input  hpcs_pkg::cfg_type cfg,
   input  hpcs_pkg::req_type item,
   input  logic              fire,
   output hpcs_pkg::rsp_type result
);

   typedef struct packed {
      logic valve;
      logic ifast;
      logic ifan;
      logic ofast;
      logic ofan;
      logic comp;
   } pin_type;

   typedef struct packed {
      pin_type     pins;
      logic        outdoor_fan_running;
      logic        indoor_fan_running;
      logic        valve_engaged;
      logic        compressor_running;
      logic        in_defrost;
      logic        in_drip;
      logic [31:0] valve_timer_start;
      logic [31:0] compressor_timer_start;
      logic [31:0] phase_start;
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state for one item, in the order outdoor fan, indoor fan, valve,
   // then compressor and defrost.
   always_comb begin
      state_in = state_ff;

      // Outdoor fan with hysteresis on the high speed relay.
      if (state_ff.in_defrost) begin
         if (state_ff.outdoor_fan_running) begin
            state_in.pins.ofan = 1'b0;
            state_in.pins.ofast = 1'b0;
            state_in.outdoor_fan_running = 1'b0;
         end
      end else begin
         if (!state_ff.outdoor_fan_running) begin
            state_in.pins.ofan = 1'b1;
            state_in.outdoor_fan_running = 1'b1;
            state_in.valve_timer_start = item.now_seconds;
         end
         if (item.outdoor_unit_temp >= cfg.ext_fast_threshold) begin
            state_in.pins.ofast = 1'b1;
         end else if (item.outdoor_unit_temp <= cfg.ext_slow_threshold) begin
            state_in.pins.ofast = 1'b0;
         end
      end

      // Indoor fan with a single speed threshold.
      if (state_ff.in_defrost) begin
         if (state_ff.indoor_fan_running) begin
            state_in.pins.ifan = 1'b0;
            state_in.pins.ifast = 1'b0;
            state_in.indoor_fan_running = 1'b0;
         end
      end else begin
         if (!state_ff.indoor_fan_running) begin
            state_in.pins.ifan = 1'b1;
            state_in.indoor_fan_running = 1'b1;
         end
         state_in.pins.ifast = (item.indoor_unit_temp >= cfg.int_fast_threshold);
      end

      // Four-way valve, timed from the outdoor fan start.
      if (!state_ff.valve_engaged &&
          hpcs_pkg::elapsed(item.now_seconds, state_in.valve_timer_start,
                            cfg.valve_delay)) begin
         state_in.pins.valve = 1'b1;
         state_in.valve_engaged = 1'b1;
         state_in.compressor_timer_start = item.now_seconds;
      end

      // Compressor start, defrost trigger, and the defrost and drip phases.
      if (state_ff.in_defrost) begin
         if (hpcs_pkg::elapsed(item.now_seconds, state_ff.phase_start,
                               cfg.defrost_time)) begin
            state_in.in_defrost = 1'b0;
            state_in.in_drip = 1'b1;
            state_in.phase_start = item.now_seconds;
         end
      end else if (state_ff.in_drip) begin
         if (hpcs_pkg::elapsed(item.now_seconds, state_ff.phase_start,
                               cfg.drip_time)) begin
            state_in.pins = '0;
            state_in.outdoor_fan_running = 1'b0;
            state_in.indoor_fan_running = 1'b0;
            state_in.compressor_running = 1'b0;
            state_in.in_defrost = 1'b0;
            state_in.in_drip = 1'b0;
            state_in.valve_engaged = 1'b0;
         end
      end else if (item.evaporator_temp <= cfg.defrost_threshold) begin
         state_in.pins = '0;
         state_in.compressor_running = 1'b0;
         state_in.in_defrost = 1'b1;
         state_in.phase_start = item.now_seconds;
      end else if (state_in.valve_engaged && !state_ff.compressor_running &&
                   hpcs_pkg::elapsed(item.now_seconds,
                                     state_in.compressor_timer_start,
                                     cfg.compressor_delay)) begin
         state_in.pins.comp = 1'b1;
         state_in.compressor_running = 1'b1;
      end
   end

   // The state advances only when an item passes to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // Result fields are taken after the update.
   always_comb begin
      result.compressor_pin   = state_in.pins.comp;
      result.outdoor_fan_pin  = state_in.pins.ofan;
      result.outdoor_fast_pin = state_in.pins.ofast;
      result.indoor_fan_pin   = state_in.pins.ifan;
      result.indoor_fast_pin  = state_in.pins.ifast;
      result.valve_pin        = state_in.pins.valve;
      result.defrost_active   = state_in.in_defrost;
      result.drip_active      = state_in.in_drip;
   end

endmodule

// ===== sv/heat_pump_cooling_sequencer_unit.sv =====
// Flow: an accepted item is held in the input register, passes through the
// combinational sequencer core and is captured in the result register.
// Throughput: one item per cycle while rsp_stall is low; the input and result
// registers both advance in the same cycle; the sequencer state updates once per item.
// Reset: synchronous, active high; clears all relay and phase state and loads
// the configuration registers with their default values.
module heat_pump_cooling_sequencer_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  hpcs_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output hpcs_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [hpcs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                      csr_wdata
);

   hpcs_pkg::cfg_type cfg;
   hpcs_pkg::req_type req_data_ff;
   hpcs_pkg::rsp_type rsp_data_ff;
   hpcs_pkg::rsp_type result;
   logic              req_valid_ff;
   logic              req_valid_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              out_free;
   logic              fire;
   logic              accept;

   // Pipeline control: the input register drains whenever the result
   // register is empty or being taken.
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign fire         = req_valid_ff && out_free;
   assign req_stall    = req_valid_ff && !out_free;
   assign accept       = req_valid && !req_stall;
   assign req_valid_in = accept || (req_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   hpcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hpcs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (req_data_ff),
      .fire   (fire),
      .result (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/hpcs_checker.sv =====
module hpcs_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input hpcs_pkg::rsp_type rsp_data
);

   // No result item is offered in the cycle after a reset cycle.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result item holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   // Defrost and drip are exclusive phases.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.defrost_active && rsp_data.drip_active))
      else $error("defrost and drip active together");

   // During defrost the compressor and both fans stay off.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.defrost_active |->
         !rsp_data.compressor_pin && !rsp_data.outdoor_fan_pin &&
         !rsp_data.outdoor_fast_pin && !rsp_data.indoor_fan_pin &&
         !rsp_data.indoor_fast_pin)
      else $error("relay on during defrost");

   // The compressor only runs with the valve engaged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.compressor_pin |-> rsp_data.valve_pin)
      else $error("compressor on without valve");

endmodule

bind heat_pump_cooling_sequencer_unit hpcs_checker u_hpcs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
